// File: rtl/lge_pkg.sv
// Shared types and constants for the life generation engine.
// No dependencies; imported by lge_cell_rule, life_generation_engine and the testbench.
`default_nettype none
package lge_pkg;

	// Operation codes carried in the op field
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_ADVANCE = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_ROWS = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;
	localparam logic [1:0] CFG_EDGE = 2'd2;

	localparam int CFG_W    = 7;
	localparam int IN_TW    = 16;
	localparam int OUT_TW   = 8;

	// B3/S23 thresholds
	typedef logic [3:0] count_t;
	localparam count_t BIRTH_COUNT  = 4'd3;
	localparam count_t SURVIVE_LOW  = 4'd2;
	localparam count_t SURVIVE_HIGH = 4'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_RD_RD,
		ST_ADV_RD1,
		ST_ADV_RD2,
		ST_ADV_CELL,
		ST_ADV_WR,
		ST_ADV_ZERO,
		ST_FIN
	} lge_state_t;

endpackage
`default_nettype wire

// File: rtl/life_generation_engine.sv
// Life generation engine (B3/S23 cellular automaton), top level.
// Depends on lge_pkg, lge_row_mem, lge_cell_rule.
//
// Usage:
//  s_* channel takes one command item: write a cell, read a cell, advance one
//  generation (op 3 is a no-op). Every item yields exactly one result item on
//  m_*, in order: cell_out (read value, else 0) and done_op (the op echoed).
//  cfg_we/cfg_index/cfg_wdata set rows_in_use, cols_in_use, edge_mode; write
//  them only while the engine is idle.
//  The grid sits in one row-wide memory holding both banks; bank_q marks the
//  current one. Cell writes are a read-modify-write of a row word.
//  A write passes states WR_RD, WR_WB and FIN, a read RD_RD and FIN; a no-op
//  or out-of-range item goes straight to FIN, where the result is registered.
//  An advance walks the in-use rows: per row ADV_RD1 and ADV_RD2 fetch the
//  rows above and below plus the row itself, ADV_CELL steps the in-use
//  columns through the single cell-rule unit, and ADV_WR writes the new row
//  to the other bank; then ADV_ZERO zeroes each unused row there.
//  One item is worked at a time; the next item is taken once the previous
//  result sits in the output register, even if the receiver stalls it.
//  After reset a clearing pass zeroes all 2*2^clog2(MAX_ROWS) row words with
//  s_tready low; config writes still land.
`default_nettype none
module life_generation_engine
	import lge_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// [1:0] op, [7:2] row, [13:8] col, [14] cell_in, [15] zero
	input  wire logic [IN_TW-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// [0] cell_out, [2:1] done_op, [7:3] zero
	output logic [OUT_TW-1:0]      m_tdata,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_wdata
);

	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW1 = $clog2(MAX_ROWS+1);
	localparam int CW1 = $clog2(MAX_COLS+1);
	localparam int AW  = RW + 1;

	// config registers
	logic [CFG_W-1:0] rows_in_use_q, cols_in_use_q;
	logic             edge_mode_q;

	// control
	lge_state_t state_q, state_d;
	logic       bank_q;
	logic [AW-1:0]  clr_q;
	logic [RW1-1:0] r_q;
	logic [CW-1:0]  c_q;
	logic           m_tvalid_q;

	// item and payload registers
	logic [1:0]          op_q;
	logic [5:0]          row_q, col_q;
	logic                cell_q, inside_q;
	logic [RW1-1:0]      nr_q;
	logic [CW1-1:0]      nc_q;
	logic                wrap_q;
	logic [MAX_COLS-1:0] up_q, next_row_q;
	logic [OUT_TW-1:0]   m_tdata_q;

	// input fields
	logic [1:0] in_op;
	logic [5:0] in_row, in_col;
	logic       in_cell, in_inside;

	// memory ports
	logic                rd_a_en, rd_b_en, wr_en;
	logic [AW-1:0]       rd_a_addr, rd_b_addr, wr_addr;
	logic [MAX_COLS-1:0] rd_a_data, rd_b_data, wr_data;

	logic [RW1-1:0] nr_eff, r_inc;
	logic [CW1-1:0] nc_eff;
	logic [RW-1:0]  up_idx, dn_idx;
	logic           up_dead, dn_dead, dn_wrap, c_last;
	logic [MAX_COLS-1:0] dn_row, rmw_word;
	logic [CW-1:0]  col_idx;
	logic           cell_next, swap, load_out, out_cell;

	assign in_op     = s_tdata[1:0];
	assign in_row    = s_tdata[7:2];
	assign in_col    = s_tdata[13:8];
	assign in_cell   = s_tdata[14];
	assign in_inside = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);

	// in-use size: 0 acts as 1, above the store acts as the store size
	assign nr_eff = (rows_in_use_q == '0) ? RW1'(1) :
		((32'(rows_in_use_q) > MAX_ROWS) ? RW1'(MAX_ROWS) : RW1'(rows_in_use_q));
	assign nc_eff = (cols_in_use_q == '0) ? CW1'(1) :
		((32'(cols_in_use_q) > MAX_COLS) ? CW1'(MAX_COLS) : CW1'(cols_in_use_q));

	// row neighbors of the row being worked
	assign r_inc   = r_q + RW1'(1);
	assign dn_wrap = (r_inc == nr_q);
	assign up_idx  = (r_q == '0) ? RW'(nr_q - RW1'(1)) : RW'(r_q - RW1'(1));
	assign up_dead = (r_q == '0) && !wrap_q;
	assign dn_idx  = dn_wrap ? '0 : RW'(r_inc);
	assign dn_dead = dn_wrap && !wrap_q;
	assign dn_row  = dn_dead ? '0 : rd_a_data;
	assign c_last  = (CW1'(c_q) + CW1'(1)) == nc_q;

	assign col_idx = CW'(col_q);

	always_comb begin
		rmw_word = rd_a_data;
		rmw_word[col_idx] = cell_q;
	end

	assign out_cell = (op_q == OP_READ) && inside_q && rd_a_data[col_idx];

	lge_row_mem #(
		.AW (AW),
		.DW (MAX_COLS)
	) u_mem (
		.clk       (clk),
		.rd_a_en   (rd_a_en),
		.rd_a_addr (rd_a_addr),
		.rd_a_data (rd_a_data),
		.rd_b_en   (rd_b_en),
		.rd_b_addr (rd_b_addr),
		.rd_b_data (rd_b_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	lge_cell_rule #(
		.MAX_COLS (MAX_COLS)
	) u_rule (
		.up_row    (up_q),
		.mid_row   (rd_b_data),
		.dn_row    (dn_row),
		.col       (c_q),
		.nc        (nc_q),
		.wrap      (wrap_q),
		.cell_next (cell_next)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		rd_a_en   = 1'b0;
		rd_a_addr = {bank_q, RW'(row_q)};
		rd_b_en   = 1'b0;
		rd_b_addr = {bank_q, r_q[RW-1:0]};
		wr_en     = 1'b0;
		wr_addr   = {!bank_q, r_q[RW-1:0]};
		wr_data   = '0;
		swap      = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (in_op)
						OP_WRITE:   state_d = in_inside ? ST_WR_RD : ST_FIN;
						OP_ADVANCE: state_d = ST_ADV_RD1;
						OP_READ:    state_d = in_inside ? ST_RD_RD : ST_FIN;
						default:    state_d = ST_FIN;
					endcase
				end
			end
			ST_WR_RD: begin
				rd_a_en = 1'b1;
				state_d = ST_WR_WB;
			end
			ST_WR_WB: begin
				wr_en   = 1'b1;
				wr_addr = {bank_q, RW'(row_q)};
				wr_data = rmw_word;
				state_d = ST_FIN;
			end
			ST_RD_RD: begin
				rd_a_en = 1'b1;
				state_d = ST_FIN;
			end
			ST_ADV_RD1: begin
				rd_a_en   = 1'b1;
				rd_a_addr = {bank_q, up_idx};
				rd_b_en   = 1'b1;
				state_d   = ST_ADV_RD2;
			end
			ST_ADV_RD2: begin
				rd_a_en   = 1'b1;
				rd_a_addr = {bank_q, dn_idx};
				state_d   = ST_ADV_CELL;
			end
			ST_ADV_CELL: begin
				if (c_last) begin
					state_d = ST_ADV_WR;
				end
			end
			ST_ADV_WR: begin
				wr_en   = 1'b1;
				wr_data = next_row_q;
				if (r_inc == nr_q) begin
					if (nr_q == RW1'(MAX_ROWS)) begin
						swap    = 1'b1;
						state_d = ST_FIN;
					end else begin
						state_d = ST_ADV_ZERO;
					end
				end else begin
					state_d = ST_ADV_RD1;
				end
			end
			ST_ADV_ZERO: begin
				wr_en = 1'b1;
				if (r_inc == RW1'(MAX_ROWS)) begin
					swap    = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= 7'd64;
			cols_in_use_q <= 7'd64;
			edge_mode_q   <= 1'b1;
			bank_q        <= 1'b0;
			clr_q         <= '0;
			r_q           <= '0;
			c_q           <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROWS: rows_in_use_q <= cfg_wdata;
					CFG_COLS: cols_in_use_q <= cfg_wdata;
					CFG_EDGE: edge_mode_q   <= cfg_wdata[0];
					default:  ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (swap) begin
				bank_q <= !bank_q;
			end
			if (state_q == ST_IDLE) begin
				r_q <= '0;
			end else if (state_q == ST_ADV_WR || state_q == ST_ADV_ZERO) begin
				r_q <= r_inc;
			end
			if (state_q == ST_ADV_RD1) begin
				c_q <= '0;
			end else if (state_q == ST_ADV_CELL) begin
				c_q <= c_q + CW'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q     <= in_op;
			row_q    <= in_row;
			col_q    <= in_col;
			cell_q   <= in_cell;
			inside_q <= in_inside;
			nr_q     <= nr_eff;
			nc_q     <= nc_eff;
			wrap_q   <= edge_mode_q;
		end
		if (state_q == ST_ADV_RD2) begin
			up_q <= up_dead ? '0 : rd_a_data;
		end
		if (state_q == ST_ADV_RD1) begin
			next_row_q <= '0;
		end else if (state_q == ST_ADV_CELL) begin
			next_row_q[c_q] <= cell_next;
		end
		if (load_out) begin
			m_tdata_q <= {5'd0, op_q, out_cell};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// port a never reads the row word that is being written in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_a_en) |-> (wr_addr != rd_a_addr))
		else $error("read and write collide on port a");

	// a generation is written only into the bank that is not current
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ADV_WR || state_q == ST_ADV_ZERO) && wr_en)
			|-> (wr_addr[AW-1] != bank_q))
		else $error("advance wrote into the current bank");

	// the cell sweep stays inside the in-use rows
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV_CELL) |-> (r_q < nr_q))
		else $error("cell sweep past last in-use row");

	// the bank flips only as an advance completes
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(bank_q) |-> (state_q == ST_FIN && op_q == OP_ADVANCE))
		else $error("bank swapped outside an advance");

endmodule
`default_nettype wire

// File: rtl/lge_row_mem.sv
// Row-wide grid store: one word per grid row, both banks in one array.
// Two registered read ports, one write port. No dependencies.
`default_nettype none
module lge_row_mem #(
	parameter int AW = 7,
	parameter int DW = 64
) (
	input  wire logic          clk,
	input  wire logic          rd_a_en,
	input  wire logic [AW-1:0] rd_a_addr,
	output logic      [DW-1:0] rd_a_data,
	input  wire logic          rd_b_en,
	input  wire logic [AW-1:0] rd_b_addr,
	output logic      [DW-1:0] rd_b_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the port is enabled again
	always_ff @(posedge clk) begin
		if (rd_a_en) begin
			rd_a_data <= mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_data <= mem[rd_b_addr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/lge_cell_rule.sv
// Next state of one cell from its three rows (B3/S23, column edge handling).
// Depends on lge_pkg.
`default_nettype none
module lge_cell_rule
	import lge_pkg::*;
#(
	parameter int MAX_COLS = 64
) (
	input  wire logic [MAX_COLS-1:0]                up_row,
	input  wire logic [MAX_COLS-1:0]                mid_row,
	input  wire logic [MAX_COLS-1:0]                dn_row,
	input  wire logic [$clog2(MAX_COLS)-1:0]        col,
	input  wire logic [$clog2(MAX_COLS+1)-1:0]      nc,
	input  wire logic                               wrap,
	output logic                                    cell_next
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int CW1 = $clog2(MAX_COLS+1);

	logic [CW1-1:0] col_inc;
	logic [CW-1:0]  lft, rgt;
	logic           lft_ok, rgt_ok, alive;
	count_t         cnt;

	always_comb begin
		col_inc = CW1'(col) + CW1'(1);
		// left neighbor column
		if (col == '0) begin
			lft    = CW'(nc - CW1'(1));
			lft_ok = wrap;
		end else begin
			lft    = col - CW'(1);
			lft_ok = 1'b1;
		end
		// right neighbor column
		if (col_inc == nc) begin
			rgt    = '0;
			rgt_ok = wrap;
		end else begin
			rgt    = CW'(col_inc);
			rgt_ok = 1'b1;
		end

		alive = mid_row[col];
		cnt = count_t'(up_row[col]) + count_t'(dn_row[col])
			+ count_t'(lft_ok & up_row[lft]) + count_t'(lft_ok & mid_row[lft])
			+ count_t'(lft_ok & dn_row[lft]) + count_t'(rgt_ok & up_row[rgt])
			+ count_t'(rgt_ok & mid_row[rgt]) + count_t'(rgt_ok & dn_row[rgt]);

		if (alive) begin
			cell_next = (cnt >= SURVIVE_LOW) && (cnt <= SURVIVE_HIGH);
		end else begin
			cell_next = (cnt == BIRTH_COUNT);
		end
	end

endmodule
`default_nettype wire

// File: dv/tb_life_generation_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for life_generation_engine: cell writes, reads and
// B3/S23 generation steps driven over the s_/m_ streams and checked against a
// behavioral grid model. Depends on lge_pkg and the engine RTL.
module tb_life_generation_engine;
	import lge_pkg::*;

	// op 3 has no name in the package; the engine just echoes it
	localparam logic [1:0] OP_NOP    = 2'd3;
	localparam logic       EDGE_DEAD = 1'b0;
	localparam logic       EDGE_WRAP = 1'b1;
	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;
	// Longest quiet stretch: a full 64x64 advance, the receiver hold-off,
	// the clearing pass; taken with lots of margin.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 300;
	// early in the first random phase, so many items are still to be offered
	localparam int HOLD_AT_RESULT = 25;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// [1:0] op, [7:2] row, [13:8] col, [14] cell_in, [15] zero
	logic [IN_TW-1:0]  s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// [0] cell_out, [2:1] done_op, [7:3] zero
	logic [OUT_TW-1:0] m_tdata;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = CFG_ROWS;
	logic [CFG_W-1:0]  cfg_wdata = '0;

	life_generation_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Grid model: both banks, which one is current, and the registers
	// ---------------------------------------------------------------
	typedef struct {
		bit         alive;
		logic [1:0] op;
	} cell_reply_t;

	bit [GRID_COLS-1:0] life_bank [2][GRID_ROWS];
	bit                 front_sel = 1'b0;
	logic [6:0]         rows_q = 7'd64;
	logic [6:0]         cols_q = 7'd64;
	logic               edge_q = EDGE_WRAP;

	cell_reply_t cell_replies [$];
	int          error_count = 0;
	int          results_taken = 0;
	bit          calm = 1'b0;       // no idling on either side once set

	// 0 acts as 1, anything past the store acts as the store size
	function automatic int effective_span(logic [6:0] v, int limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	// Neighbour at (r+dr, c+dc) inside the nr x nc in-use region
	function automatic bit neighbour_at(int r, int c, int dr, int dc, int nr, int nc);
		int rr;
		int cc;
		rr = r + dr;
		cc = c + dc;
		if (rr < 0 || rr >= nr) begin
			if (edge_q == EDGE_DEAD)
				return 1'b0;
			rr = (rr < 0) ? nr - 1 : 0;
		end
		if (cc < 0 || cc >= nc) begin
			if (edge_q == EDGE_DEAD)
				return 1'b0;
			cc = (cc < 0) ? nc - 1 : 0;
		end
		return life_bank[front_sel][rr][cc];
	endfunction

	// One generation into the back bank; cells outside the region die
	function automatic void evolve_generation();
		int nr;
		int nc;
		int cnt;
		bit [GRID_COLS-1:0] nxt [GRID_ROWS];
		nr = effective_span(rows_q, GRID_ROWS);
		nc = effective_span(cols_q, GRID_COLS);
		for (int r = 0; r < GRID_ROWS; r++)
			nxt[r] = '0;
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				cnt = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if (dr != 0 || dc != 0)
							cnt += neighbour_at(r, c, dr, dc, nr, nc);
				if (life_bank[front_sel][r][c])
					nxt[r][c] = (cnt >= SURVIVE_LOW && cnt <= SURVIVE_HIGH);
				else
					nxt[r][c] = (cnt == BIRTH_COUNT);
			end
		end
		for (int r = 0; r < GRID_ROWS; r++)
			life_bank[!front_sel][r] = nxt[r];
		front_sel = !front_sel;
	endfunction

	// Apply one accepted command to the model and return the reply it gives
	function automatic cell_reply_t apply_command(logic [1:0] op, logic [5:0] row,
			logic [5:0] col, bit cell_in);
		cell_reply_t reply;
		reply.op = op;
		reply.alive = 1'b0;
		case (op)
			OP_WRITE:   life_bank[front_sel][row][col] = cell_in;
			OP_ADVANCE: evolve_generation();
			OP_READ:    reply.alive = life_bank[front_sel][row][col];
			default:    ;
		endcase
		return reply;
	endfunction

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	// Offer one item from the falling edge on, hold it until taken, then
	// queue the reply. A typed reply replaces the model's cell value.
	task automatic send_item(logic [1:0] op, logic [5:0] row, logic [5:0] col,
			bit cell_in, bit typed, bit typed_alive);
		cell_reply_t reply;
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, cell_in, col, row, op};
		do @(posedge clk); while (!s_tready);
		reply = apply_command(op, row, col, cell_in);
		if (typed)
			reply.alive = typed_alive;
		cell_replies.push_back(reply);
	endtask

	task automatic drain_replies();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (cell_replies.size() != 0)
			@(posedge clk);
	endtask

	// Registers are only written with the engine idle (every reply is back)
	task automatic program_grid(logic [6:0] rows_w, logic [6:0] cols_w, logic edge_w);
		drain_replies();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_wdata <= rows_w;
		@(negedge clk);
		cfg_index <= CFG_COLS;
		cfg_wdata <= cols_w;
		@(negedge clk);
		cfg_index <= CFG_EDGE;
		cfg_wdata <= {6'd0, edge_w};
		@(negedge clk);
		cfg_we <= 1'b0;
		rows_q = rows_w;
		cols_q = cols_w;
		edge_q = edge_w;
	endtask

	// Mostly indexes inside the in-use region, sometimes anywhere in the store
	function automatic logic [5:0] pick_index(int span);
		if ($urandom_range(0, 99) < 80)
			return 6'($urandom_range(0, span - 1));
		return 6'($urandom_range(0, 63));
	endfunction

	// Directed rows, run at the reset setting (64x64, wrap)
	typedef struct {
		logic [1:0] op;
		logic [5:0] row;
		logic [5:0] col;
		bit         cell_in;
		bit         typed;
		bit         typed_alive;
	} stim_row_t;

	stim_row_t opening_rows [20] = '{
		'{OP_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b0},  // fresh store is dead
		'{OP_READ,    6'd63, 6'd63, 1'b0, 1'b1, 1'b0},
		'{OP_WRITE,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
		'{OP_READ,    6'd63, 6'd63, 1'b0, 1'b1, 1'b1},
		'{OP_WRITE,   6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
		'{OP_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b1},
		'{OP_NOP,     6'd63, 6'd63, 1'b1, 1'b1, 1'b0},  // unused op: echo only
		'{OP_WRITE,   6'd0,  6'd63, 1'b1, 1'b1, 1'b0},  // blinker across the wrap
		'{OP_WRITE,   6'd0,  6'd1,  1'b1, 1'b1, 1'b0},
		'{OP_ADVANCE, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
		'{OP_READ,    6'd63, 6'd0,  1'b0, 1'b0, 1'b0},
		'{OP_READ,    6'd1,  6'd0,  1'b0, 1'b0, 1'b0},
		'{OP_READ,    6'd0,  6'd63, 1'b0, 1'b0, 1'b0},
		'{OP_READ,    6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
		'{OP_WRITE,   6'd31, 6'd32, 1'b0, 1'b0, 1'b0},
		'{OP_WRITE,   6'd42, 6'd21, 1'b1, 1'b0, 1'b0},
		'{OP_READ,    6'd42, 6'd21, 1'b0, 1'b0, 1'b0},
		'{OP_ADVANCE, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
		'{OP_READ,    6'd42, 6'd21, 1'b0, 1'b0, 1'b0},  // lone cell died
		'{OP_READ,    6'd0,  6'd0,  1'b0, 1'b0, 1'b0}
	};

	// Random phases: register setting, item count, cap on advances.
	// Sizes 0 and above 64 exercise the clamping; the full grid gets at most one advance.
	typedef struct {
		logic [6:0] rows_w;
		logic [6:0] cols_w;
		logic       edge_w;
		int         n_items;
		int         max_adv;
	} grid_phase_t;

	grid_phase_t phase_plan [9] = '{
		'{7'd5,   7'd6,   EDGE_DEAD, 22, 6},
		'{7'd0,   7'd0,   EDGE_WRAP, 10, 3},  // 1x1: the cell is its own neighbour
		'{7'd2,   7'd2,   EDGE_WRAP, 14, 4},
		'{7'd127, 7'd3,   EDGE_DEAD, 14, 2},
		'{7'd3,   7'd100, EDGE_WRAP, 14, 2},
		'{7'd1,   7'd7,   EDGE_DEAD, 12, 3},
		'{7'd8,   7'd8,   EDGE_WRAP, 20, 5},
		'{7'd64,  7'd64,  EDGE_DEAD, 12, 1},
		'{7'd6,   7'd5,   EDGE_WRAP, 22, 5}
	};

	initial begin
		int nr;
		int nc;
		int adv_left;
		int pick;
		logic [1:0] op;
		for (int b = 0; b < 2; b++)
			for (int r = 0; r < GRID_ROWS; r++)
				life_bank[b][r] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part; the first items wait out the clearing pass
		foreach (opening_rows[i])
			send_item(opening_rows[i].op, opening_rows[i].row, opening_rows[i].col,
				opening_rows[i].cell_in, opening_rows[i].typed,
				opening_rows[i].typed_alive);

		foreach (phase_plan[p]) begin
			program_grid(phase_plan[p].rows_w, phase_plan[p].cols_w, phase_plan[p].edge_w);
			if (p == $size(phase_plan) - 1)
				calm = 1'b1;
			nr = effective_span(rows_q, GRID_ROWS);
			nc = effective_span(cols_q, GRID_COLS);
			adv_left = phase_plan[p].max_adv;
			for (int k = 0; k < phase_plan[p].n_items; k++) begin
				// writes seed patterns, advances evolve them, reads look
				pick = $urandom_range(0, 99);
				if (pick < 45)
					op = OP_WRITE;
				else if (pick < 60 && adv_left > 0) begin
					op = OP_ADVANCE;
					adv_left--;
				end else if (pick < 95)
					op = OP_READ;
				else
					op = OP_NOP;
				send_item(op, pick_index(nr), pick_index(nc),
					$urandom_range(0, 99) < 60, 1'b0, 1'b0);
			end
		end

		drain_replies();
		// then idle on to catch any stray result
		repeat (16) @(posedge clk);
		if (error_count == 0)
			$display("[life_generation_engine] OK");
		else
			$display("[life_generation_engine] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Receiver side: random stall bursts, plus one long hold-off that
	// backs the engine up while the sender keeps offering
	// ---------------------------------------------------------------
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_taken >= HOLD_AT_RESULT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!calm && $urandom_range(0, 99) < 10) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Each result is checked against the oldest queued reply
	always @(posedge clk) begin
		cell_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_taken++;
			if (cell_replies.size() == 0) begin
				$error("result with nothing queued: cell_out %0d done_op %0d",
					m_tdata[0], m_tdata[2:1]);
				error_count++;
			end else begin
				want = cell_replies.pop_front();
				if (m_tdata[0] !== want.alive) begin
					$error("cell_out expected %0d got %0d", want.alive, m_tdata[0]);
					error_count++;
				end
				if (m_tdata[2:1] !== want.op) begin
					$error("done_op expected %0d got %0d", want.op, m_tdata[2:1]);
					error_count++;
				end
			end
		end
	end

	// Watchdog: ends the run after a long stretch with no handshake
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[life_generation_engine] ERROR");
			$finish;
		end
	end

endmodule
